// File: rtl/bdch_pkg.sv
// ----------------------------------------------------------------------------
// bdch_pkg
// Types and constants shared by the button debounce and gesture blocks.
// ----------------------------------------------------------------------------
package bdch_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned ACK_W   = 7;
    localparam int unsigned FLAG_W  = 6;
    localparam int unsigned CIDX_W  = 2;

    // Event flag positions, shared with the acknowledge mask.
    localparam int unsigned EV_PRESSED  = 0;
    localparam int unsigned EV_RELEASED = 1;
    localparam int unsigned EV_CLICK    = 2;
    localparam int unsigned EV_DOUBLE   = 3;
    localparam int unsigned EV_HOLD     = 4;
    localparam int unsigned EV_REPEAT   = 5;
    localparam int unsigned ACK_COUNT   = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    // Register indexes on the configuration port.
    localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HOLD     = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_REPEAT   = 2'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
    localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd400;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd700;
    localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd300;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] click_timeout;
        logic [CFG_W-1:0] hold_time;
        logic [CFG_W-1:0] repeat_interval;
    } cfg_t;

    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
        logic [ACK_W-1:0]  ack_mask;
    } sample_t;

    typedef struct packed {
        logic              debounced_level;
        logic [FLAG_W-1:0] flags;
        logic [CNT_W-1:0]  click_total;
    } result_t;

endpackage

// File: rtl/bdch_cfg.sv
// ----------------------------------------------------------------------------
// bdch_cfg
// Timing registers for the debouncer, written through a plain write port.
// ----------------------------------------------------------------------------
module bdch_cfg
    import bdch_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time   <= DEBOUNCE_RST;
            cfg_reg.click_timeout   <= TIMEOUT_RST;
            cfg_reg.hold_time       <= HOLD_RST;
            cfg_reg.repeat_interval <= REPEAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE: cfg_reg.debounce_time   <= cfg_wdata;
                CFG_TIMEOUT:  cfg_reg.click_timeout   <= cfg_wdata;
                CFG_HOLD:     cfg_reg.hold_time       <= cfg_wdata;
                CFG_REPEAT:   cfg_reg.repeat_interval <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/bdch_step.sv
// ----------------------------------------------------------------------------
// bdch_step
// Debounce and gesture state with the combinational update for one sample.
// ----------------------------------------------------------------------------
module bdch_step
    import bdch_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  sample_t sample,
    input  cfg_t    cfg,
    output result_t result
);

    logic              stable_reg, stable_next;
    logic              prev_raw_reg, prev_raw_next;
    logic [TIME_W-1:0] change_stamp_reg, change_stamp_next;
    logic [TIME_W-1:0] press_stamp_reg, press_stamp_next;
    logic [TIME_W-1:0] click_stamp_reg, click_stamp_next;
    logic [TIME_W-1:0] repeat_stamp_reg, repeat_stamp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic              hold_active_reg, hold_active_next;

    logic              changed;
    logic              deb_ok;
    logic              press;
    logic              release_ev;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_click;
    logic [TIME_W-1:0] since_repeat;
    logic              short_press;
    logic              hold_reached;
    logic              repeat_due;

    always_comb begin
        now     = sample.now_ms;
        changed = sample.raw_level != prev_raw_reg;

        // All time differences wrap; a fresh change or press has age zero.
        since_change = now - change_stamp_reg;
        since_press  = now - press_stamp_reg;
        since_click  = now - click_stamp_reg;
        since_repeat = now - repeat_stamp_reg;

        deb_ok = changed ? (cfg.debounce_time == '0)
                         : (since_change >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time});
        press      = deb_ok && (stable_reg != sample.raw_level) && !sample.raw_level;
        release_ev = deb_ok && (stable_reg != sample.raw_level) &&  sample.raw_level;

        short_press  = since_press < {{(TIME_W-CFG_W){1'b0}}, cfg.hold_time};
        hold_reached = press ? (cfg.hold_time == '0) : !short_press;
        repeat_due   = since_repeat >= {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_interval};

        flags_next        = flags_reg & ~sample.ack_mask[FLAG_W-1:0];
        count_next        = sample.ack_mask[ACK_COUNT] ? '0 : count_reg;
        prev_raw_next     = sample.raw_level;
        change_stamp_next = changed ? now : change_stamp_reg;
        stable_next       = stable_reg;
        press_stamp_next  = press_stamp_reg;
        click_stamp_next  = click_stamp_reg;
        repeat_stamp_next = repeat_stamp_reg;
        hold_active_next  = hold_active_reg;

        if (press) begin
            stable_next           = 1'b0;
            flags_next[EV_PRESSED] = 1'b1;
            flags_next[EV_HOLD]    = 1'b0;
            flags_next[EV_REPEAT]  = 1'b0;
            press_stamp_next      = now;
            hold_active_next      = 1'b0;
            repeat_stamp_next     = now;
        end else if (release_ev) begin
            stable_next             = 1'b1;
            flags_next[EV_RELEASED] = 1'b1;
            if (short_press) begin
                flags_next[EV_CLICK] = 1'b1;
                if (count_next != COUNT_MAX) begin
                    count_next = count_next + 1'b1;
                end
                // A zero stamp means there is no earlier click to pair with.
                if (click_stamp_reg != '0 &&
                    since_click <= {{(TIME_W-CFG_W){1'b0}}, cfg.click_timeout}) begin
                    flags_next[EV_DOUBLE] = 1'b1;
                end
                click_stamp_next = now;
            end else begin
                click_stamp_next = '0;
            end
        end

        if (!stable_next) begin
            if (!hold_active_next && hold_reached) begin
                hold_active_next    = 1'b1;
                flags_next[EV_HOLD] = 1'b1;
                repeat_stamp_next   = now;
            end else if (hold_active_next && repeat_due) begin
                flags_next[EV_REPEAT] = 1'b1;
                repeat_stamp_next     = now;
            end
        end

        result.debounced_level = stable_next;
        result.flags           = flags_next;
        result.click_total     = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg       <= 1'b1;
            prev_raw_reg     <= 1'b1;
            change_stamp_reg <= '0;
            press_stamp_reg  <= '0;
            click_stamp_reg  <= '0;
            repeat_stamp_reg <= '0;
            count_reg        <= '0;
            flags_reg        <= '0;
            hold_active_reg  <= 1'b0;
        end else if (step_en) begin
            stable_reg       <= stable_next;
            prev_raw_reg     <= prev_raw_next;
            change_stamp_reg <= change_stamp_next;
            press_stamp_reg  <= press_stamp_next;
            click_stamp_reg  <= click_stamp_next;
            repeat_stamp_reg <= repeat_stamp_next;
            count_reg        <= count_next;
            flags_reg        <= flags_next;
            hold_active_reg  <= hold_active_next;
        end
    end

    // Without a count acknowledge the click count never goes down.
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !sample.ack_mask[ACK_COUNT] |=> count_reg >= $past(count_reg))
        else $error("click count decreased without acknowledge");

    // A new press disarms hold unless the hold time is zero.
    a_press_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && press && cfg.hold_time != '0 |=> !hold_active_reg)
        else $error("hold still armed after a new press");

    // A repeat can only be raised while hold is active.
    a_repeat_needs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !flags_reg[EV_REPEAT] && flags_next[EV_REPEAT] |-> hold_active_next)
        else $error("repeat raised without an active hold");

    // A double click is always raised together with a click.
    a_double_with_click: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !flags_reg[EV_DOUBLE] && flags_next[EV_DOUBLE]
        |-> flags_next[EV_CLICK] && release_ev)
        else $error("double click raised without a click");

endmodule

// File: rtl/button_debounce_click_hold.sv
// ----------------------------------------------------------------------------
// button_debounce_click_hold
// Debouncer and click, double click, hold and repeat detector for one button.
// ----------------------------------------------------------------------------
// Each input beat on the s_ channel carries one sample of an active-low button
// with the current millisecond time and an acknowledge mask that clears chosen
// sticky flags and the click count before the sample is processed. Every input
// beat yields exactly one result beat on the m_ channel carrying the debounced
// level, the six sticky event flags and the saturating click count.
// A beat accepted at a clock edge is held in the input register, processed by
// one combinational pass of the update logic, and its result is loaded into
// the output register once that register is free or draining. One beat is
// accepted every cycle while the receiver keeps up; the bound is the feedback
// of the gesture state through the update logic.
// The timing registers are written through the cfg_ port and should be
// changed only while no beats are in flight.
// Reset clears the timers, flags and count, sets the level to released and
// loads the default timings. If the receiver stalls, the output register and
// then the input register hold their beats and s_tready falls.
// ----------------------------------------------------------------------------
module button_debounce_click_hold
    import bdch_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [0] raw_level, [32:1] now_ms, [39:33] ack_mask
    input  logic [39:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] debounced_level, [1] pressed_event, [2] released_event,
    // [3] click_event, [4] double_click_event, [5] hold_event,
    // [6] repeat_event, [14:7] click_total, [15] zero
    output logic [15:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    cfg_t    cfg;
    sample_t in_data_reg;
    logic    in_valid_reg;
    result_t step_result;
    result_t out_data_reg;
    logic    out_valid_reg;
    logic    advance;

    bdch_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held sample moves on whenever the output register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg.raw_level <= s_tdata[0];
            in_data_reg.now_ms    <= s_tdata[32:1];
            in_data_reg.ack_mask  <= s_tdata[39:33];
        end
    end

    bdch_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .sample  (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.click_total, out_data_reg.flags,
                       out_data_reg.debounced_level};

endmodule

// File: verif/button_debounce_click_hold_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_click_hold_tb
// Self-checking bench for the button debouncer and gesture detector.
// ----------------------------------------------------------------------------
// Button samples are sent as input beats with a free-running millisecond
// time. A short directed opening covers bounce, click, double click, hold,
// acknowledged hold, repeat, a long release, the time wrap and a click at
// time zero. It is followed by randomised press and release gestures with
// some noise under several timing settings: all zero, all at maximum, a
// click count saturation run, small and random values. A scoreboard
// predicts every status beat and compares it with the block's output. Both
// sides stall at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module button_debounce_click_hold_tb;
    import bdch_pkg::*;

    localparam int unsigned ITEMS          = 1850;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned HOLDOFF_AT     = 400;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    class button_scoreboard;
        logic [CFG_W-1:0]  debounce_ms;
        logic [CFG_W-1:0]  timeout_ms;
        logic [CFG_W-1:0]  hold_ms;
        logic [CFG_W-1:0]  repeat_ms;

        logic              stable_lvl;
        logic              last_raw;
        logic [TIME_W-1:0] change_t;
        logic [TIME_W-1:0] press_t;
        logic [TIME_W-1:0] click_t;
        logic [TIME_W-1:0] repeat_t;
        logic [CNT_W-1:0]  clicks;
        logic [FLAG_W-1:0] flags;
        logic              holding;

        logic [15:0]       status_q[$];
        int unsigned       n_samples;
        int unsigned       n_checked;
        int unsigned       n_bad;
        int unsigned       n_click;
        int unsigned       n_double;
        int unsigned       n_hold;
        int unsigned       n_repeat;
        int unsigned       n_ceiling;

        function new();
            debounce_ms = DEBOUNCE_RST;
            timeout_ms  = TIMEOUT_RST;
            hold_ms     = HOLD_RST;
            repeat_ms   = REPEAT_RST;
            stable_lvl  = 1'b1;
            last_raw    = 1'b1;
            change_t    = '0;
            press_t     = '0;
            click_t     = '0;
            repeat_t    = '0;
            clicks      = '0;
            flags       = '0;
            holding     = 1'b0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE: debounce_ms = val;
                CFG_TIMEOUT:  timeout_ms  = val;
                CFG_HOLD:     hold_ms     = val;
                CFG_REPEAT:   repeat_ms   = val;
                default: ;
            endcase
        endfunction

        // Advances the button state by one sample and queues the status word
        // that the block must return for it.
        function void predict_status(logic [39:0] beat);
            logic              raw;
            logic [TIME_W-1:0] now;
            logic [ACK_W-1:0]  ack;
            logic [TIME_W-1:0] since;
            raw = beat[0];
            now = beat[32:1];
            ack = beat[39:33];
            n_samples++;

            flags = flags & ~ack[FLAG_W-1:0];
            if (ack[ACK_COUNT])
                clicks = '0;

            if (raw != last_raw) begin
                last_raw = raw;
                change_t = now;
            end

            since = now - change_t;
            if (since >= debounce_ms && stable_lvl != raw) begin
                stable_lvl = raw;
                if (!raw) begin
                    flags[EV_PRESSED] = 1'b1;
                    flags[EV_HOLD]    = 1'b0;
                    flags[EV_REPEAT]  = 1'b0;
                    press_t  = now;
                    holding  = 1'b0;
                    repeat_t = now;
                end else begin
                    flags[EV_RELEASED] = 1'b1;
                    since = now - press_t;
                    if (since < hold_ms) begin
                        flags[EV_CLICK] = 1'b1;
                        n_click++;
                        if (clicks != COUNT_MAX)
                            clicks++;
                        else
                            n_ceiling++;
                        // A stamp of zero stands for no earlier click.
                        since = now - click_t;
                        if (click_t != '0 && since <= timeout_ms) begin
                            flags[EV_DOUBLE] = 1'b1;
                            n_double++;
                        end
                        click_t = now;
                    end else begin
                        click_t = '0;
                    end
                end
            end

            if (!stable_lvl) begin
                since = now - press_t;
                if (!holding && since >= hold_ms) begin
                    holding  = 1'b1;
                    flags[EV_HOLD] = 1'b1;
                    repeat_t = now;
                    n_hold++;
                end else if (holding) begin
                    since = now - repeat_t;
                    if (since >= repeat_ms) begin
                        flags[EV_REPEAT] = 1'b1;
                        repeat_t = now;
                        n_repeat++;
                    end
                end
            end

            status_q.push_back({1'b0, clicks, flags, stable_lvl});
        endfunction

        function void check_status(logic [15:0] got);
            logic [15:0] want;
            if (status_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: status beat %h with nothing expected", $time, got);
                return;
            end
            want = status_q.pop_front();
            n_checked++;
            if (got !== want) begin
                n_bad++;
                // Flags are printed from repeat down to pressed.
                if (n_bad <= 10) begin
                    $display("%0t: status %0d (expected/actual):", $time, n_checked);
                    $display("  level %b/%b flags %b/%b clicks %0d/%0d pad %b/%b",
                             want[0], got[0], want[6:1], got[6:1],
                             want[14:7], got[14:7], want[15], got[15]);
                end
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;
    logic              cfg_wr_en;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;

    button_scoreboard  sb = new();
    logic [TIME_W-1:0] clock_ms;
    int unsigned       n_sent;
    int unsigned       n_settings;
    int unsigned       cycles = 0;
    bit                keep_count;

    button_debounce_click_hold u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d status beats outstanding.",
                     cycles, sb.status_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Both handshakes are sampled at the falling edge ahead of the rising edge that
    // completes them, when every signal involved has settled.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.predict_status(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_status(m_tdata);
        end
    end

    // Receiver: random stalls, a steady stretch, and one long hold-off.
    initial begin
        bit held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_off && sb.n_samples >= HOLDOFF_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= (sb.n_samples >= 900 && sb.n_samples < 1250) ||
                            ($urandom_range(0, 99) >= 28);
            end
        end
    end

    task automatic send_sample(input logic raw, input logic [TIME_W-1:0] ms,
                               input logic [ACK_W-1:0] ack);
        logic rdy;
        while (!(n_sent >= 900 && n_sent < 1200) && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ack, ms, raw};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        n_sent++;
    endtask

    function automatic logic [ACK_W-1:0] pick_ack();
        logic [ACK_W-1:0] ack;
        ack = '0;
        if ($urandom_range(0, 99) < 25) begin
            ack = ACK_W'($urandom_range(0, 127));
            if (keep_count)
                ack[ACK_COUNT] = 1'b0;
        end
        return ack;
    endfunction

    function automatic logic [CFG_W-1:0] pick_timing();
        if ($urandom_range(0, 99) < 70)
            return CFG_W'($urandom_range(0, 200));
        return CFG_W'($urandom_range(0, 65535));
    endfunction

    // Waits until every status beat is back and the pipeline has emptied.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.status_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_timings(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] tmo,
                                input logic [CFG_W-1:0] hld, input logic [CFG_W-1:0] rpt);
        logic [CIDX_W-1:0] idx;
        logic [CFG_W-1:0]  val;
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: begin idx = CFG_DEBOUNCE; val = deb; end
                1: begin idx = CFG_TIMEOUT;  val = tmo; end
                2: begin idx = CFG_HOLD;     val = hld; end
                default: begin idx = CFG_REPEAT; val = rpt; end
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(posedge aclk);
            sb.set_reg(idx, val);
        end
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Holds one level from now for span milliseconds over a few samples.
    task automatic settle_level(input logic lvl, input logic [TIME_W-1:0] span);
        int unsigned       pieces;
        logic [TIME_W-1:0] left;
        logic [TIME_W-1:0] piece;
        send_sample(lvl, clock_ms, pick_ack());
        pieces = $urandom_range(1, 3);
        left   = span;
        for (int i = 0; i < pieces; i++) begin
            piece = (i == pieces - 1) ? left : $urandom_range(0, left);
            left     -= piece;
            clock_ms += piece;
            send_sample(lvl, clock_ms, pick_ack());
        end
    endtask

    // Contact bounce: level flips spaced well inside the debounce window.
    task automatic bounce(input logic lvl);
        int unsigned n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            clock_ms += $urandom_range(0, sb.debounce_ms / 2);
            send_sample(lvl ^ i[0], clock_ms, pick_ack());
        end
    endtask

    // One press and release, with press and gap lengths spread either side of
    // the hold time and the double click timeout.
    task automatic gesture();
        logic [TIME_W-1:0] span;
        if ($urandom_range(0, 99) < 30)
            bounce(1'b0);
        if ($urandom_range(0, 99) < 60)
            span = sb.debounce_ms + $urandom_range(0, sb.hold_ms);
        else
            span = sb.debounce_ms + sb.hold_ms + $urandom_range(0, 3 * sb.repeat_ms + 2);
        settle_level(1'b0, span);
        if ($urandom_range(0, 99) < 30)
            bounce(1'b1);
        if ($urandom_range(0, 99) < 60)
            span = sb.debounce_ms + $urandom_range(0, sb.timeout_ms);
        else
            span = sb.debounce_ms + sb.timeout_ms + $urandom_range(1, sb.timeout_ms + 50);
        settle_level(1'b1, span);
    endtask

    task automatic noise();
        if ($urandom_range(0, 99) < 10)
            clock_ms = $urandom();
        else
            clock_ms += $urandom_range(0, 2 * sb.debounce_ms + 2);
        send_sample(1'($urandom_range(0, 1)), clock_ms, pick_ack());
    endtask

    initial begin
        int unsigned target;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= CFG_DEBOUNCE;
        cfg_wdata  <= '0;
        n_sent     = 0;
        n_settings = 1;
        keep_count = 1'b0;
        clock_ms   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default timings: bounce, click, double click, clear all, hold,
        // hold acknowledge without refire, repeat, long release, time wrap.
        send_sample(1'b1, 32'd0,    '0);
        send_sample(1'b0, 32'd5,    '0);
        send_sample(1'b1, 32'd8,    '0);
        send_sample(1'b0, 32'd10,   '0);
        send_sample(1'b0, 32'd40,   '0);
        send_sample(1'b1, 32'd100,  '0);
        send_sample(1'b1, 32'd130,  '0);
        send_sample(1'b0, 32'd200,  '0);
        send_sample(1'b0, 32'd230,  '0);
        send_sample(1'b1, 32'd300,  '0);
        send_sample(1'b1, 32'd330,  '0);
        send_sample(1'b1, 32'd340,  7'h7F);
        send_sample(1'b0, 32'd400,  '0);
        send_sample(1'b0, 32'd430,  '0);
        send_sample(1'b0, 32'd1130, '0);
        send_sample(1'b0, 32'd1200, 7'(1 << EV_HOLD));
        send_sample(1'b0, 32'd1430, '0);
        send_sample(1'b1, 32'd1460, '0);
        send_sample(1'b1, 32'd1490, '0);
        send_sample(1'b0, 32'hFFFF_FFF0, '0);
        send_sample(1'b0, 32'h0000_0010, '0);
        send_sample(1'b1, 32'h0000_0020, '0);
        send_sample(1'b1, 32'h0000_003E, '0);

        // With no debounce a click lands exactly at time zero, so the next
        // click must not count as a double.
        drain();
        load_timings(16'd0, TIMEOUT_RST, HOLD_RST, REPEAT_RST);
        send_sample(1'b0, 32'hFFFF_FFF0, '0);
        send_sample(1'b1, 32'd0,  '0);
        send_sample(1'b0, 32'd5,  '0);
        send_sample(1'b1, 32'd10, '0);
        clock_ms = 32'd10;

        for (int setting = 0; n_sent < ITEMS; setting++) begin
            drain();
            case (setting)
                0: load_timings(16'd0, 16'd0, 16'd0, 16'd0);
                1: load_timings(16'd0, 16'hFFFF, 16'hFFFF, 16'd7);
                2: load_timings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_timings(16'd5, 16'd60, 16'd100, 16'd0);
                4: load_timings(16'd1, 16'd120, 16'd40, 16'd15);
                default: load_timings(pick_timing(), pick_timing(), pick_timing(),
                                      pick_timing());
            endcase
            if (setting == 1) begin
                // Quick taps with the count never cleared drive it into its ceiling.
                keep_count = 1'b1;
                repeat (280) begin
                    clock_ms += 1;
                    send_sample(1'b0, clock_ms, pick_ack());
                    clock_ms += 1;
                    send_sample(1'b1, clock_ms, pick_ack());
                end
                keep_count = 1'b0;
            end else begin
                target = n_sent + 220;
                while (n_sent < target && n_sent < ITEMS) begin
                    if ($urandom_range(0, 99) < 80)
                        gesture();
                    else
                        noise();
                end
            end
        end

        drain();
        $display("Checked %0d status beats over %0d timing settings and one %0d-cycle stall.",
                 sb.n_checked, n_settings, HOLDOFF_CYCLES);
        $display("Saw %0d clicks, %0d doubles, %0d holds, %0d repeats; %0d at count ceiling.",
                 sb.n_click, sb.n_double, sb.n_hold, sb.n_repeat, sb.n_ceiling);
        if (sb.n_bad == 0 && sb.status_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total.", sb.n_bad);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: button_debounce_click_hold.f
rtl/bdch_pkg.sv
rtl/bdch_cfg.sv
rtl/bdch_step.sv
rtl/button_debounce_click_hold.sv
verif/button_debounce_click_hold_tb.sv
